// File: rtl/rs485tx_pkg.sv
// Shared types and constants for the RS485 transmit queue.
package rs485tx_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 64;

    localparam logic [7:0] HOLD_RESET = 8'd8;
    localparam logic [7:0] HOLD_MIN   = 8'd2;
    localparam logic [7:0] SEND_TICK  = 8'd1;

    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POLL = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // input beat taken this cycle
        logic fetch_held;  // capture queue RAM read data into held byte
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic poll_go;     // current input is a start poll that will take a byte
    } t_dp_stat;

endpackage

// File: rtl/rs485tx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rs485tx_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/rs485tx_ctrl.sv
// Handshake controller: input/output beat flow and the RAM fetch wait state.
module rs485tx_ctrl
    import rs485tx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept) begin
            n_out_valid = 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_stat.poll_go) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cmd.accept     = w_accept;
    assign o_cmd.fetch_held = (r_state == S_FETCH);

endmodule

// File: rtl/rs485tx_dp.sv
// Datapath: queue pointers, byte RAM, send/hold sequencing, config register, result register.
module rs485tx_dp
    import rs485tx_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    input  logic [1:0]        i_operation,
    input  logic [7:0]        i_tx_data,
    input  t_ctrl_cmd         i_cmd,
    output t_dp_stat          o_stat,
    output logic              o_uart_write,
    output logic [7:0]        o_uart_byte,
    output logic              o_driver_enable,
    output logic              o_sender_busy,
    output logic              o_push_dropped,
    output logic              o_queue_empty
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [PTR_W-1:0] r_write_pos, n_write_pos;
    logic [PTR_W-1:0] r_read_pos, n_read_pos;
    logic             r_busy, n_busy;
    logic             r_enable, n_enable;
    logic [7:0]       r_hold_count, n_hold_count;
    logic [7:0]       r_held_byte;
    logic [7:0]       r_hold_ticks;

    logic             r_uart_write, n_uart_write;
    logic [7:0]       r_uart_byte;
    logic             r_push_dropped, n_push_dropped;
    logic             r_queue_empty;

    logic [PTR_W-1:0] w_wr_next, w_rd_next;
    logic [7:0]       w_limit, w_count_inc;
    logic             w_ram_we;
    logic [7:0]       w_ram_rd_data;
    logic             w_cfg_we;

    assign w_wr_next   = (r_write_pos == PTR_LAST) ? '0 : r_write_pos + 1'b1;
    assign w_rd_next   = (r_read_pos == PTR_LAST) ? '0 : r_read_pos + 1'b1;
    assign w_limit     = (r_hold_ticks < HOLD_MIN) ? HOLD_MIN : r_hold_ticks;
    assign w_count_inc = r_hold_count + 8'd1;

    assign o_stat.poll_go = (t_op'(i_operation) == OP_POLL) &&
                            (r_write_pos != r_read_pos) && !r_busy;

    always_comb begin
        n_write_pos    = r_write_pos;
        n_read_pos     = r_read_pos;
        n_busy         = r_busy;
        n_enable       = r_enable;
        n_hold_count   = r_hold_count;
        n_uart_write   = 1'b0;
        n_push_dropped = 1'b0;
        w_ram_we       = 1'b0;
        if (i_cmd.accept) begin
            case (t_op'(i_operation))
                OP_PUSH: begin
                    if (w_wr_next == r_read_pos) begin
                        n_push_dropped = 1'b1;
                    end else begin
                        w_ram_we    = 1'b1;
                        n_write_pos = w_wr_next;
                    end
                end
                OP_POLL: begin
                    if (o_stat.poll_go) begin
                        n_busy     = 1'b1;
                        n_enable   = 1'b1;
                        n_read_pos = w_rd_next;
                    end
                end
                OP_TICK: begin
                    if (r_busy) begin
                        n_hold_count = w_count_inc;
                        if (w_count_inc == SEND_TICK) begin
                            n_uart_write = 1'b1;
                        end else if (w_count_inc >= w_limit) begin
                            n_enable     = 1'b0;
                            n_busy       = 1'b0;
                            n_hold_count = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // byte is read at poll accept, captured on the following cycle
    rs485tx_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (r_write_pos),
        .i_wr_data (i_tx_data),
        .i_rd_en   (i_cmd.accept && o_stat.poll_go),
        .i_rd_addr (r_read_pos),
        .o_rd_data (w_ram_rd_data)
    );

    assign w_cfg_we = psel && penable && pwrite && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_pos  <= '0;
            r_read_pos   <= '0;
            r_busy       <= 1'b0;
            r_enable     <= 1'b0;
            r_hold_count <= '0;
            r_held_byte  <= '0;
            r_hold_ticks <= HOLD_RESET;
        end else begin
            r_write_pos  <= n_write_pos;
            r_read_pos   <= n_read_pos;
            r_busy       <= n_busy;
            r_enable     <= n_enable;
            r_hold_count <= n_hold_count;
            if (i_cmd.fetch_held) begin
                r_held_byte <= w_ram_rd_data;
            end
            if (w_cfg_we) begin
                r_hold_ticks <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_uart_write   <= n_uart_write;
            r_uart_byte    <= n_uart_write ? r_held_byte : 8'd0;
            r_push_dropped <= n_push_dropped;
            r_queue_empty  <= (n_write_pos == n_read_pos);
        end
    end

    assign prdata = paddr[2] ? '0 : {{(APB_DW-8){1'b0}}, r_hold_ticks};

    assign o_uart_write    = r_uart_write;
    assign o_uart_byte     = r_uart_byte;
    assign o_driver_enable = r_enable;
    assign o_sender_busy   = r_busy;
    assign o_push_dropped  = r_push_dropped;
    assign o_queue_empty   = r_queue_empty;

endmodule

// File: rtl/rs485_tx_fifo_direction_control.sv
// RS485 transmit queue with driver-enable sequencing, top level.
//
// Each input beat is a push, a start poll or a delay tick and yields one result beat.
// A push, a tick, an unused code and a poll that takes nothing are done when taken; a
// poll that takes a byte also waits in a fetch state on the queue RAM's registered
// read port. Results sit in an output register, so the next beat is taken while a
// result is handed off. The queue holds QUEUE_DEPTH-1 bytes; a push into a full queue
// is dropped and flagged. The RAM needs no clearing after reset: an entry is read only
// after it was pushed. hold_ticks sits at byte address 0 of the APB port (reset 8;
// values below 2 act as 2) and should be written only while no beat is in flight.
module rs485_tx_fifo_direction_control
    import rs485tx_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_operation,
    input  logic [7:0]        i_tx_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_uart_write,
    output logic [7:0]        o_uart_byte,
    output logic              o_driver_enable,
    output logic              o_sender_busy,
    output logic              o_push_dropped,
    output logic              o_queue_empty
);

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    assign pready = 1'b1;

    rs485tx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    rs485tx_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .i_operation     (i_operation),
        .i_tx_data       (i_tx_data),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_uart_write    (o_uart_write),
        .o_uart_byte     (o_uart_byte),
        .o_driver_enable (o_driver_enable),
        .o_sender_busy   (o_sender_busy),
        .o_push_dropped  (o_push_dropped),
        .o_queue_empty   (o_queue_empty)
    );

endmodule

// File: rtl/rs485tx_chk.sv
// Port-level checker for the RS485 transmit queue, bound to the top level.
module rs485tx_chk
    import rs485tx_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_uart_write,
    input logic [7:0] o_uart_byte,
    input logic       o_driver_enable,
    input logic       o_sender_busy
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    // a stalled result beat keeps its byte
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_uart_byte))
        else $error("stalled result beat changed");

    // the byte goes out only while the bus is driven and the sender is busy
    a_send_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_uart_write |-> o_driver_enable && o_sender_busy)
        else $error("UART write without driver enable");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_uart_write |-> o_uart_byte == 8'd0)
        else $error("UART byte nonzero without write");

    a_enable_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_driver_enable |-> o_sender_busy)
        else $error("driver enable without busy sender");

endmodule

bind rs485_tx_fifo_direction_control rs485tx_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_uart_write    (o_uart_write),
    .o_uart_byte     (o_uart_byte),
    .o_driver_enable (o_driver_enable),
    .o_sender_busy   (o_sender_busy)
);

// File: tb/sv/rs485_tx_fifo_direction_control_tb.sv
// Self-checking testbench for the RS485 transmit queue with driver-enable sequencing.
`timescale 1ns / 1ps

module rs485_tx_fifo_direction_control_tb;
    import rs485tx_pkg::*;

    localparam int unsigned          PTR_W     = $clog2(QUEUE_DEPTH_DEF);
    localparam logic [1:0]           OP_SPARE  = 2'd3;
    localparam logic [APB_AW-1:0]    HOLD_ADDR = '0;
    localparam int                   LONG_HOLD = 400;
    localparam int                   MAX_PRINT = 60;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } t_beat;

    typedef struct packed {
        logic       uart_write;
        logic [7:0] uart_byte;
        logic       drv_en;
        logic       busy;
        logic       dropped;
        logic       empty;
    } t_line_status;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_operation = OP_PUSH;
    logic [7:0]        i_tx_data   = 8'h00;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_uart_write;
    logic [7:0]        o_uart_byte;
    logic              o_driver_enable;
    logic              o_sender_busy;
    logic              o_push_dropped;
    logic              o_queue_empty;

    rs485_tx_fifo_direction_control dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_tx_data      (i_tx_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_uart_write   (o_uart_write),
        .o_uart_byte    (o_uart_byte),
        .o_driver_enable(o_driver_enable),
        .o_sender_busy  (o_sender_busy),
        .o_push_dropped (o_push_dropped),
        .o_queue_empty  (o_queue_empty)
    );

    always #1 i_clk = ~i_clk;

    // shadow copy of the queue, sender and hold register
    logic [7:0]       fifo_mem [QUEUE_DEPTH_DEF];
    logic [PTR_W-1:0] wr_ptr    = '0;
    logic [PTR_W-1:0] rd_ptr    = '0;
    logic             sending   = 1'b0;
    logic [7:0]       held      = 8'h00;
    logic [7:0]       tick_cnt  = 8'h00;
    logic             de_line   = 1'b0;
    logic [7:0]       hold_cfg  = HOLD_RESET;

    t_beat          beats_to_send [$];
    t_line_status   line_status_q [$];
    int             queued_cnt   = 0;
    int             accepted_cnt = 0;
    int             result_cnt   = 0;
    int             err_cnt      = 0;
    logic           in_fire      = 1'b0;
    logic           out_fire     = 1'b0;

    int             send_gap   = 0;
    bit             send_burst = 1'b0;
    t_beat          drv_beat;
    int             recv_gap   = 0;
    bit             recv_burst = 1'b0;
    int             hold_asks  = 0;
    int             hold_seen  = 0;
    int             hold_left  = 0;

    function automatic t_line_status predict_line_status(input logic [1:0] op,
                                                         input logic [7:0] data);
        t_line_status res;
        logic [7:0]   limit;
        res = '0;
        case (op)
            OP_PUSH: begin
                if (wr_ptr + 1'b1 == rd_ptr) begin
                    res.dropped = 1'b1;
                end else begin
                    fifo_mem[wr_ptr] = data;
                    wr_ptr = wr_ptr + 1'b1;
                end
            end
            OP_POLL: begin
                if (wr_ptr != rd_ptr && !sending) begin
                    de_line = 1'b1;
                    sending = 1'b1;
                    held    = fifo_mem[rd_ptr];
                    rd_ptr  = rd_ptr + 1'b1;
                end
            end
            OP_TICK: begin
                if (sending) begin
                    limit    = (hold_cfg < HOLD_MIN) ? HOLD_MIN : hold_cfg;
                    tick_cnt = tick_cnt + 8'd1;
                    if (tick_cnt == SEND_TICK) begin
                        res.uart_write = 1'b1;
                        res.uart_byte  = held;
                    end else if (tick_cnt >= limit) begin
                        de_line  = 1'b0;
                        sending  = 1'b0;
                        tick_cnt = 8'h00;
                    end
                end
            end
            default: ;
        endcase
        res.drv_en = de_line;
        res.busy   = sending;
        res.empty  = (wr_ptr == rd_ptr);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        err_cnt++;
        if (err_cnt <= MAX_PRINT)
            $display("ERROR result %0d: %s expected 0x%0h got 0x%0h",
                     result_cnt, what, want, got);
    endtask

    // sender: one beat per pull from the pending list, random gap before the next
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (beats_to_send.size() > 0) begin
                drv_beat = beats_to_send.pop_front();
                i_operation <= drv_beat.op;
                i_tx_data   <= drv_beat.data;
                i_in_valid  <= 1'b1;
                if ($urandom_range(0, 63) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 5);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall per beat, plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (out_fire) begin
                if ($urandom_range(0, 63) == 0)
                    recv_burst = !recv_burst;
                recv_gap = recv_burst ? 0 : $urandom_range(0, 5);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // monitor: check the result beat first, then predict the accepted input beat
    always @(posedge i_clk) begin : monitor
        t_line_status want;
        in_fire  <= i_rst_n && i_in_valid && o_in_ready;
        out_fire <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (line_status_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 8'h00, 8'h00);
                end else begin
                    want = line_status_q.pop_front();
                    if (o_uart_write !== want.uart_write)
                        report_mismatch("uart_write", 8'(want.uart_write),
                                        8'(o_uart_write));
                    if (o_uart_byte !== want.uart_byte)
                        report_mismatch("uart_byte", want.uart_byte, o_uart_byte);
                    if (o_driver_enable !== want.drv_en)
                        report_mismatch("driver_enable", 8'(want.drv_en),
                                        8'(o_driver_enable));
                    if (o_sender_busy !== want.busy)
                        report_mismatch("sender_busy", 8'(want.busy), 8'(o_sender_busy));
                    if (o_push_dropped !== want.dropped)
                        report_mismatch("push_dropped", 8'(want.dropped),
                                        8'(o_push_dropped));
                    if (o_queue_empty !== want.empty)
                        report_mismatch("queue_empty", 8'(want.empty), 8'(o_queue_empty));
                end
                result_cnt++;
            end
            if (i_in_valid && o_in_ready) begin
                line_status_q.push_back(predict_line_status(i_operation, i_tx_data));
                accepted_cnt++;
            end
        end
    end

    task automatic queue_beat(input logic [1:0] op, input logic [7:0] data);
        beats_to_send.push_back('{op: op, data: data});
        queued_cnt++;
    endtask

    task automatic queue_random(input int n, input int w_push, input int w_poll,
                                input int w_tick);
        int r;
        logic [1:0] op;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, w_push + w_poll + w_tick - 1);
            if ($urandom_range(0, 99) < 3)
                op = OP_SPARE;
            else if (r < w_push)
                op = OP_PUSH;
            else if (r < w_push + w_poll)
                op = OP_POLL;
            else
                op = OP_TICK;
            queue_beat(op, 8'($urandom_range(0, 255)));
        end
    endtask

    // well-formed frames: 1 to 4 pushes, then per byte a poll and hold-1 to hold+1 ticks
    task automatic queue_frames(input int frames);
        int nbytes;
        int ticks;
        for (int f = 0; f < frames; f++) begin
            nbytes = $urandom_range(1, 4);
            for (int b = 0; b < nbytes; b++)
                queue_beat(OP_PUSH, 8'($urandom_range(0, 255)));
            for (int b = 0; b < nbytes; b++) begin
                queue_beat(OP_POLL, 8'($urandom_range(0, 255)));
                ticks = ((hold_cfg < HOLD_MIN) ? HOLD_MIN : hold_cfg)
                        + $urandom_range(0, 2) - 1;
                for (int t = 0; t < ticks; t++)
                    queue_beat(OP_TICK, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0)
                    queue_random(2, 1, 1, 1);
            end
        end
    endtask

    task automatic wait_drained();
        while (!(accepted_cnt == queued_cnt && line_status_q.size() == 0))
            @(negedge i_clk);
    endtask

    // APB write of hold_ticks followed by a read-back
    task automatic write_hold(input logic [7:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HOLD_ADDR;
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        hold_cfg = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== value)
            report_mismatch("hold_ticks read-back", value, prdata[7:0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle corner cases, byte extremes, busy poll, full hold at reset value
        queue_beat(OP_POLL, 8'h00);
        queue_beat(OP_TICK, 8'h00);
        queue_beat(OP_SPARE, 8'hFF);
        queue_beat(OP_PUSH, 8'h00);
        queue_beat(OP_PUSH, 8'hFF);
        queue_beat(OP_PUSH, 8'h5A);
        queue_beat(OP_POLL, 8'hFF);
        queue_beat(OP_POLL, 8'h00);
        queue_beat(OP_PUSH, 8'hA5);
        for (int t = 0; t < 8; t++)
            queue_beat(OP_TICK, 8'($urandom_range(0, 255)));
        queue_beat(OP_TICK, 8'h00);
        queue_beat(OP_POLL, 8'h00);
        for (int t = 0; t < 3; t++)
            queue_beat(OP_TICK, 8'hFF);
        wait_drained();

        // short hold settings behave as two
        write_hold(8'd0);
        queue_frames(20);
        queue_random(100, 1, 1, 1);
        wait_drained();

        write_hold(8'd1);
        queue_random(150, 1, 1, 1);
        wait_drained();

        // longest hold: queue fills and drops pushes, and the receiver holds off once
        write_hold(8'd255);
        for (int k = 0; k < 70; k++)
            queue_beat(OP_PUSH, 8'($urandom_range(0, 255)));
        hold_asks++;
        queue_random(150, 2, 1, 2);
        wait_drained();

        write_hold(8'd2);
        queue_random(400, 15, 25, 60);
        queue_frames(10);
        wait_drained();

        repeat (2) begin
            write_hold(8'($urandom_range(3, 20)));
            queue_frames(8);
            queue_random(120, 1, 1, 1);
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #500000;
        $display("Some tests failed");
        $finish;
    end

endmodule
